// ===== rtl/ncc_pkg.sv =====
// Shared sizes, field widths and codes for the nearest-centroid classifier.
// Depends on nothing; every other file of the block imports it.
package ncc_pkg;

    localparam int MAX_CLUSTERS  = 8;
    localparam int MAX_FEATURES  = 16;
    localparam int FEATURE_BITS  = 16;

    localparam int CL_BITS       = $clog2(MAX_CLUSTERS);
    localparam int FT_BITS       = $clog2(MAX_FEATURES);
    localparam int ADDR_BITS     = CL_BITS + FT_BITS;
    localparam int CENT_DEPTH    = MAX_CLUSTERS * MAX_FEATURES;
    localparam int ACC_BITS      = 40;
    localparam int SQ_BITS       = 2 * (FEATURE_BITS + 1);
    localparam int CNT_BITS      = FT_BITS + 1;
    localparam int ISS_BITS      = CL_BITS + 1;

    localparam int AC_BITS       = 4;
    localparam int AF_BITS       = 5;
    localparam int CFG_DATA_BITS = 5;

    localparam logic [AC_BITS-1:0] AC_RESET = AC_BITS'(8);
    localparam logic [AF_BITS-1:0] AF_RESET = AF_BITS'(16);

    localparam logic CFG_ACTIVE_CLUSTERS = 1'b0;
    localparam logic CFG_ACTIVE_FEATURES = 1'b1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [ACC_BITS-1:0] ACC_MAX = '1;

    // One centroid slot moving through the distance pipeline.
    typedef struct packed {
        logic               vld;
        logic [CL_BITS-1:0] k;
    } stage_t;

    // Updated accumulator value leaving the distance unit.
    typedef struct packed {
        logic                vld;
        logic [CL_BITS-1:0]  k;
        logic [ACC_BITS-1:0] sum;
    } result_t;

endpackage

// ===== rtl/ncc_cent_mem.sv =====
// Centroid element store: one write port, one read port, registered read data.
// Depends on ncc_pkg for the depth and element width.
module ncc_cent_mem (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [ncc_pkg::ADDR_BITS-1:0]     wr_addr,
    input  logic [ncc_pkg::FEATURE_BITS-1:0]  wr_data,
    input  logic                              rd_en,
    input  logic [ncc_pkg::ADDR_BITS-1:0]     rd_addr,
    output logic [ncc_pkg::FEATURE_BITS-1:0]  rd_data
);
    import ncc_pkg::*;

    logic [FEATURE_BITS-1:0] mem [CENT_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/ncc_dist_unit.sv =====
// Shared distance datapath: difference, square, saturating accumulate into the
// per-centroid accumulator bank, one centroid per cycle. Depends on ncc_pkg.
module ncc_dist_unit (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  ncc_pkg::stage_t                         issue,
    input  logic signed [ncc_pkg::FEATURE_BITS-1:0] query,
    input  logic [ncc_pkg::FEATURE_BITS-1:0]        cent,
    input  logic                                    last,
    output ncc_pkg::result_t                        res
);
    import ncc_pkg::*;

    stage_t                  s1_reg;
    stage_t                  s2_reg;
    logic [SQ_BITS-1:0]      sq_reg;
    logic [ACC_BITS-1:0]     acc_reg [MAX_CLUSTERS];
    result_t                 res_reg;

    logic signed [FEATURE_BITS:0]  diff;
    logic signed [SQ_BITS-1:0]     sq_full;
    logic [ACC_BITS:0]             sum_wide;
    logic [ACC_BITS-1:0]           sum_next;

    assign diff    = $signed({query[FEATURE_BITS-1], query})
                   - $signed({cent[FEATURE_BITS-1], cent});
    assign sq_full = diff * diff;

    assign sum_wide = {1'b0, acc_reg[s2_reg.k]} + (ACC_BITS + 1)'(sq_reg);
    assign sum_next = sum_wide[ACC_BITS] ? ACC_MAX : sum_wide[ACC_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg  <= '0;
            s2_reg  <= '0;
            res_reg <= '0;
            for (int i = 0; i < MAX_CLUSTERS; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            s1_reg      <= issue;
            s2_reg      <= s1_reg;
            res_reg.vld <= s2_reg.vld;
            res_reg.k   <= s2_reg.k;
            if (s2_reg.vld)
            begin
                res_reg.sum <= sum_next;
                // The last feature of a point hands the sum on and clears the slot.
                acc_reg[s2_reg.k] <= last ? '0 : sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_reg.vld)
        begin
            sq_reg <= SQ_BITS'($unsigned(sq_full));
        end
    end

    assign res = res_reg;

endmodule

// ===== rtl/nearest_centroid_classifier.sv =====
// Nearest-centroid classifier. A load beat writes one centroid element. A
// query beat carries the next feature of a point; it runs the eight centroids
// one by one through the single read port of the centroid store and a shared
// subtract, square and accumulate unit, and no new beat is taken until it is
// through. On the last feature of a point the block then waits in ST_EMIT
// until the output register is free and hands the result to it. The result
// gives the lowest-index active centroid with the smallest squared distance
// and that distance; the output register lets the next beat enter while the
// result waits. Depends on ncc_pkg, ncc_cent_mem, ncc_dist_unit.
module nearest_centroid_classifier (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    kind,
    input  logic [ncc_pkg::CL_BITS-1:0]             cluster_index,
    input  logic [ncc_pkg::FT_BITS-1:0]             feature_index,
    input  logic signed [ncc_pkg::FEATURE_BITS-1:0] value,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [ncc_pkg::CL_BITS-1:0]             nearest_cluster,
    output logic [ncc_pkg::ACC_BITS-1:0]            squared_distance,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic                                    cfg_index,
    input  logic [ncc_pkg::CFG_DATA_BITS-1:0]       cfg_data
);
    import ncc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]               state_reg;
    logic [1:0]               state_next;
    logic [AC_BITS-1:0]       ac_reg;
    logic [AF_BITS-1:0]       af_reg;
    logic [CNT_BITS-1:0]      feat_cnt_reg;
    logic [FT_BITS-1:0]       pos_reg;
    logic                     last_reg;
    logic [FEATURE_BITS-1:0]  query_reg;
    logic [ISS_BITS-1:0]      iss_cnt_reg;
    logic [ACC_BITS-1:0]      best_reg;
    logic [CL_BITS-1:0]       best_idx_reg;
    logic                     out_valid_reg;
    logic [CL_BITS-1:0]       out_idx_reg;
    logic [ACC_BITS-1:0]      out_dist_reg;

    logic [AC_BITS-1:0]       nc;
    logic [AF_BITS-1:0]       nf;
    logic                     accept;
    logic                     is_last;
    logic                     done;
    logic                     take_best;
    logic                     out_free;
    stage_t                   issue;
    result_t                  res;
    logic [FEATURE_BITS-1:0]  cent;

    assign nc = (ac_reg == '0) ? AC_BITS'(1)
              : ((ac_reg > AC_BITS'(MAX_CLUSTERS)) ? AC_BITS'(MAX_CLUSTERS) : ac_reg);
    assign nf = (af_reg == '0) ? AF_BITS'(1)
              : ((af_reg > AF_BITS'(MAX_FEATURES)) ? AF_BITS'(MAX_FEATURES) : af_reg);

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign is_last   = ((CNT_BITS + 1)'(feat_cnt_reg) + (CNT_BITS + 1)'(1))
                       >= (CNT_BITS + 1)'(nf);
    assign out_free  = !out_valid_reg || out_ready;

    assign issue.vld = (state_reg == ST_RUN) && (iss_cnt_reg < ISS_BITS'(MAX_CLUSTERS));
    assign issue.k   = iss_cnt_reg[CL_BITS-1:0];

    assign done = res.vld && (res.k == CL_BITS'(MAX_CLUSTERS - 1));
    // Slot zero seeds the search; later active slots win only when strictly smaller.
    assign take_best = res.vld && ((res.k == '0)
                     || ((AC_BITS'(res.k) < nc) && (res.sum < best_reg)));

    ncc_cent_mem u_mem (
        .clk     (clk),
        .wr_en   (accept && (kind == KIND_LOAD)),
        .wr_addr ({cluster_index, feature_index}),
        .wr_data (value),
        .rd_en   (issue.vld),
        .rd_addr ({issue.k, pos_reg}),
        .rd_data (cent)
    );

    ncc_dist_unit u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .issue (issue),
        .query (query_reg),
        .cent  (cent),
        .last  (last_reg),
        .res   (res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (kind == KIND_QUERY))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (done)
                begin
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ac_reg        <= AC_RESET;
            af_reg        <= AF_RESET;
            feat_cnt_reg  <= '0;
            iss_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_ACTIVE_CLUSTERS: ac_reg <= cfg_data[AC_BITS-1:0];
                    CFG_ACTIVE_FEATURES: af_reg <= cfg_data[AF_BITS-1:0];
                    default:             ac_reg <= ac_reg;
                endcase
            end
            if (accept && (kind == KIND_QUERY))
            begin
                feat_cnt_reg <= is_last ? '0 : (feat_cnt_reg + CNT_BITS'(1));
                iss_cnt_reg  <= '0;
            end
            else if (issue.vld)
            begin
                iss_cnt_reg <= iss_cnt_reg + ISS_BITS'(1);
            end
            if ((state_reg == ST_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (kind == KIND_QUERY))
        begin
            query_reg <= value;
            pos_reg   <= feat_cnt_reg[FT_BITS-1:0];
            last_reg  <= is_last;
        end
        if (take_best)
        begin
            best_reg     <= res.sum;
            best_idx_reg <= res.k;
        end
        if ((state_reg == ST_EMIT) && out_free)
        begin
            out_idx_reg  <= best_idx_reg;
            out_dist_reg <= best_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign nearest_cluster  = out_idx_reg;
    assign squared_distance = out_dist_reg;

    a_res_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        res.vld |-> (state_reg == ST_RUN))
        else $error("accumulator result outside of a query run");

    a_emit_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> last_reg)
        else $error("result emitted on a feature that does not end the point");

    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_EMIT))
        else $error("output beat raised without a finished point");

    a_feat_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        feat_cnt_reg < CNT_BITS'(MAX_FEATURES))
        else $error("feature counter ran past the last feature");

endmodule
